// ===== hw/rtl/rsiw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsiw_pkg: shared types and constants for the Wilder RSI stream
// Widths, reset values, FSM encodings and the divider lane control word.
// ----------------------------------------------------------------------------
package rsiw_pkg;

  localparam int unsigned FRAC_BITS_DEF  = 16;
  localparam int unsigned PRICE_BITS_DEF = 32;

  localparam int unsigned PRICE_IN_W = 32;
  localparam int unsigned PERIOD_W   = 10;
  localparam logic [PERIOD_W-1:0] PERIOD_RST = 10'd14;

  // averages live in a full 64-bit word so that odd period changes wrap as expected
  localparam int unsigned ST_W   = 64;
  // ratio operands are pre-scaled below 2^NORM_W
  localparam int unsigned NORM_W = 60;

  localparam int unsigned OUT_W    = 23;
  localparam int unsigned OUT_FRAC = 16;
  localparam logic [OUT_W-1:0] RSI_FULL = OUT_W'(100 << OUT_FRAC);

  typedef enum logic [3:0] {
    S_IDLE,
    S_GAIN,
    S_PREP,
    S_LDAVG,
    S_DIV,
    S_POST,
    S_RSTART,
    S_RWAIT,
    S_OUT
  } ctl_state_t;

  typedef enum logic [2:0] {
    R_IDLE,
    R_NORM,
    R_SHIFT,
    R_SUB,
    R_DONE
  } ratio_state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic feed_zero;
  } lane_ctl_t;

endpackage

// ===== hw/rtl/rsiw_div_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsiw_div_lane: bit-serial divider lane
// Restoring division by the period, one quotient bit per cycle while step is set. Dividend and
// quotient share one shift register; feed_zero extends the dividend with zeros.
// ----------------------------------------------------------------------------
module rsiw_div_lane (
  input  logic                            clk,
  input  rsiw_pkg::lane_ctl_t             ctl,
  input  logic [rsiw_pkg::ST_W-1:0]       load_val,
  input  logic [rsiw_pkg::PERIOD_W-1:0]   divisor,
  output logic [rsiw_pkg::ST_W-1:0]       quot,
  output logic                            rem_nz
);
  import rsiw_pkg::*;

  logic [ST_W-1:0]     sh_r, sh_nxt;
  logic [PERIOD_W-1:0] rem_r, rem_nxt;
  logic [PERIOD_W:0]   trial;
  logic [PERIOD_W:0]   trial_sub;
  logic                in_bit;
  logic                fits;

  always_comb begin
    // past the dividend, the top bit is a quotient bit and must not re-enter
    in_bit    = ctl.feed_zero ? 1'b0 : sh_r[ST_W-1];
    trial     = {rem_r, in_bit};
    trial_sub = trial - {1'b0, divisor};
    fits      = (trial >= {1'b0, divisor});
    sh_nxt    = sh_r;
    rem_nxt   = rem_r;
    if (ctl.load) begin
      sh_nxt  = load_val;
      rem_nxt = '0;
    end else if (ctl.step) begin
      sh_nxt  = {sh_r[ST_W-2:0], fits};
      rem_nxt = fits ? trial_sub[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    sh_r  <= sh_nxt;
    rem_r <= rem_nxt;
  end

  assign quot   = sh_r;
  assign rem_nz = |rem_r;

endmodule

// ===== hw/rtl/rsiw_ratio.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsiw_ratio: RSI ratio unit
// floor(100.0 * G / (G + L)) in Q7.16, one output bit per shift/subtract
// round; full scale when L is zero.
// ----------------------------------------------------------------------------
module rsiw_ratio (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [rsiw_pkg::ST_W-1:0]     g_in,
  input  logic [rsiw_pkg::ST_W-1:0]     l_in,
  output logic                          done,
  output logic [rsiw_pkg::OUT_W-1:0]    q
);
  import rsiw_pkg::*;

  localparam int unsigned SUM_W = NORM_W + 1;
  localparam int unsigned REM_W = NORM_W + 3;
  localparam int unsigned IDX_W = $clog2(OUT_W);

  ratio_state_t     state_r, state_nxt;
  logic [ST_W-1:0]  g_r, g_nxt;
  logic [ST_W-1:0]  l_r, l_nxt;
  logic [SUM_W-1:0] s_r, s_nxt;
  logic [REM_W-1:0] r_r, r_nxt;
  logic [OUT_W-1:0] q_r, q_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             too_wide;
  logic [REM_W-1:0] g_add;

  assign too_wide = (|g_r[ST_W-1:NORM_W]) | (|l_r[ST_W-1:NORM_W]);
  assign g_add    = RSI_FULL[idx_r] ? REM_W'(g_r[NORM_W-1:0]) : '0;

  always_comb begin
    state_nxt = state_r;
    g_nxt     = g_r;
    l_nxt     = l_r;
    s_nxt     = s_r;
    r_nxt     = r_r;
    q_nxt     = q_r;
    idx_nxt   = idx_r;
    case (state_r)
      R_IDLE: begin
        if (start) begin
          g_nxt = g_in;
          l_nxt = l_in;
          if (l_in == '0) begin
            q_nxt     = RSI_FULL;
            state_nxt = R_DONE;
          end else begin
            state_nxt = R_NORM;
          end
        end
      end
      R_NORM: begin
        if (too_wide) begin
          g_nxt = g_r >> 1;
          l_nxt = l_r >> 1;
        end else if (g_r == '0 && l_r == '0) begin
          q_nxt     = RSI_FULL;
          state_nxt = R_DONE;
        end else begin
          s_nxt     = SUM_W'(g_r[NORM_W-1:0]) + SUM_W'(l_r[NORM_W-1:0]);
          r_nxt     = '0;
          q_nxt     = '0;
          idx_nxt   = IDX_W'(OUT_W - 1);
          state_nxt = R_SHIFT;
        end
      end
      R_SHIFT: begin
        r_nxt     = {r_r[REM_W-2:0], 1'b0} + g_add;
        q_nxt     = {q_r[OUT_W-2:0], 1'b0};
        state_nxt = R_SUB;
      end
      R_SUB: begin
        // remainder may reach up to three times the sum: repeat the subtract
        if (r_r >= REM_W'(s_r)) begin
          r_nxt = r_r - REM_W'(s_r);
          q_nxt = q_r + 1'b1;
        end else if (idx_r == '0) begin
          state_nxt = R_DONE;
        end else begin
          idx_nxt   = idx_r - 1'b1;
          state_nxt = R_SHIFT;
        end
      end
      R_DONE: begin
        state_nxt = R_IDLE;
      end
      default: begin
        state_nxt = R_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= R_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    g_r   <= g_nxt;
    l_r   <= l_nxt;
    s_r   <= s_nxt;
    r_r   <= r_nxt;
    q_r   <= q_nxt;
    idx_r <= idx_nxt;
  end

  assign done = (state_r == R_DONE);
  assign q    = q_r;

endmodule

// ===== hw/rtl/rsi_wilder_stream.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_wilder_stream: streaming RSI with Wilder smoothing
// One price word in, one RSI word out (Q7.16); bit-serial dividers by period.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | in_price[31:0], in_first
//  out     | output    | out_valid/out_stall| out_rsi_value[22:0], out_valid_res
//  cfg     | input     | cfg_valid/cfg_ready| cfg_period[9:0]
//
//  Warm-up words pass through the gain, prep and output states; the word that
//  closes warm-up also runs 64 + FRAC_BITS bit-serial division steps by period.
//  Smoothed words run 64 divider steps plus the 23-bit ratio loop, which
//  takes a shift and repeated subtract steps per result bit (the loop is
//  skipped when the loss average is zero).
//  Synchronous active-low reset; period resets to 14 and the series restarts.
//  A stalled result is held in the output register while the next word is
//  processed; that word then waits at the end until the register frees up.
// ----------------------------------------------------------------------------
module rsi_wilder_stream #(
  parameter int unsigned FRAC_BITS  = rsiw_pkg::FRAC_BITS_DEF,
  parameter int unsigned PRICE_BITS = rsiw_pkg::PRICE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [rsiw_pkg::PRICE_IN_W-1:0] in_price,
  input  logic                           in_first,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [rsiw_pkg::OUT_W-1:0]     out_rsi_value,
  output logic                           out_valid_res,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rsiw_pkg::PERIOD_W-1:0]  cfg_period
);
  import rsiw_pkg::*;

  localparam int unsigned CNT_W = $clog2(ST_W + FRAC_BITS + 1);
  localparam logic [CNT_W-1:0] LAST_WILDER = CNT_W'(ST_W - 1);
  localparam logic [CNT_W-1:0] LAST_AVG    = CNT_W'(ST_W + FRAC_BITS - 1);

  ctl_state_t          state_r, state_nxt;
  logic [PERIOD_W-1:0] period_r;
  logic [PERIOD_W-1:0] p_eff;

  logic [PRICE_BITS-1:0] price_r, price_nxt;
  logic                  first_r, first_nxt;
  logic [PRICE_BITS-1:0] prev_r, prev_nxt;
  logic [PERIOD_W-1:0]   idx_r, idx_nxt;
  logic [PERIOD_W-1:0]   n_r, n_nxt;
  logic [PRICE_BITS-1:0] gain_r, gain_nxt;
  logic [PRICE_BITS-1:0] loss_r, loss_nxt;
  logic [ST_W-1:0]       avg_g_r, avg_g_nxt;
  logic [ST_W-1:0]       avg_l_r, avg_l_nxt;
  logic                  ge_g_r, ge_g_nxt;
  logic                  ge_l_r, ge_l_nxt;
  logic                  avg_mode_r, avg_mode_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [OUT_W-1:0]      res_value_r, res_value_nxt;
  logic                  res_ok_r, res_ok_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]      out_value_r, out_value_nxt;
  logic                  out_ok_r, out_ok_nxt;

  logic [PERIOD_W-1:0] n_sel;
  logic [PERIOD_W:0]   n_inc;
  logic [PERIOD_W-1:0] p_last;
  logic [ST_W-1:0]     x_g, x_l;
  logic                ge_g, ge_l;
  logic [ST_W-1:0]     dif_g, dif_l;
  logic [ST_W-1:0]     post_g, post_l;

  lane_ctl_t           lane_ctl;
  logic [ST_W-1:0]     lane_g_val, lane_l_val;
  logic [ST_W-1:0]     quot_g, quot_l;
  logic                nz_g, nz_l;

  logic                ratio_start;
  logic                ratio_done;
  logic [OUT_W-1:0]    ratio_q;
  logic                out_take;

  // config register: a zero period behaves as one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RST;
    end else if (cfg_valid) begin
      period_r <= cfg_period;
    end
  end

  assign cfg_ready = 1'b1;
  assign p_eff     = (period_r == '0) ? PERIOD_W'(1) : period_r;
  assign p_last    = p_eff - 1'b1;

  assign n_sel = first_r ? '0 : idx_r;
  assign n_inc = {1'b0, n_sel} + 1'b1;

  // Wilder step: avg becomes avg + (x - avg) / period, rounded down
  assign x_g    = ST_W'(gain_r) << FRAC_BITS;
  assign x_l    = ST_W'(loss_r) << FRAC_BITS;
  assign ge_g   = (x_g >= avg_g_r);
  assign ge_l   = (x_l >= avg_l_r);
  assign dif_g  = ge_g ? (x_g - avg_g_r) : (avg_g_r - x_g);
  assign dif_l  = ge_l ? (x_l - avg_l_r) : (avg_l_r - x_l);
  assign post_g = ge_g_r ? (avg_g_r + quot_g) : (avg_g_r + ~quot_g + ST_W'(!nz_g));
  assign post_l = ge_l_r ? (avg_l_r + quot_l) : (avg_l_r + ~quot_l + ST_W'(!nz_l));

  assign out_take = out_valid_r && !out_stall;

  always_comb begin
    state_nxt     = state_r;
    price_nxt     = price_r;
    first_nxt     = first_r;
    prev_nxt      = prev_r;
    idx_nxt       = idx_r;
    n_nxt         = n_r;
    gain_nxt      = gain_r;
    loss_nxt      = loss_r;
    avg_g_nxt     = avg_g_r;
    avg_l_nxt     = avg_l_r;
    ge_g_nxt      = ge_g_r;
    ge_l_nxt      = ge_l_r;
    avg_mode_nxt  = avg_mode_r;
    cnt_nxt       = cnt_r;
    res_value_nxt = res_value_r;
    res_ok_nxt    = res_ok_r;
    out_value_nxt = out_value_r;
    out_ok_nxt    = out_ok_r;
    out_valid_nxt = out_take ? 1'b0 : out_valid_r;
    lane_ctl      = '0;
    lane_g_val    = avg_g_r;
    lane_l_val    = avg_l_r;
    ratio_start   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          price_nxt = PRICE_BITS'(in_price);
          first_nxt = in_first;
          state_nxt = S_GAIN;
        end
      end
      S_GAIN: begin
        n_nxt = n_sel;
        if (price_r > prev_r) begin
          gain_nxt = price_r - prev_r;
          loss_nxt = '0;
        end else begin
          gain_nxt = '0;
          loss_nxt = prev_r - price_r;
        end
        prev_nxt  = price_r;
        idx_nxt   = (n_inc < {1'b0, p_eff}) ? n_inc[PERIOD_W-1:0] : p_eff;
        state_nxt = S_PREP;
      end
      S_PREP: begin
        res_value_nxt = '0;
        res_ok_nxt    = 1'b0;
        if (n_r == '0) begin
          // series start: averages cleared; with period one, smoothing starts from zero
          avg_g_nxt = '0;
          avg_l_nxt = '0;
          state_nxt = S_OUT;
        end else if (n_r < p_eff) begin
          avg_g_nxt = avg_g_r + ST_W'(gain_r);
          avg_l_nxt = avg_l_r + ST_W'(loss_r);
          state_nxt = (n_r == p_last) ? S_LDAVG : S_OUT;
        end else begin
          lane_ctl.load = 1'b1;
          lane_g_val    = dif_g;
          lane_l_val    = dif_l;
          ge_g_nxt      = ge_g;
          ge_l_nxt      = ge_l;
          avg_mode_nxt  = 1'b0;
          cnt_nxt       = '0;
          state_nxt     = S_DIV;
        end
      end
      S_LDAVG: begin
        // sum -> average: sum * 2^FRAC_BITS / period, low word kept
        lane_ctl.load = 1'b1;
        avg_mode_nxt  = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        lane_ctl.step      = 1'b1;
        lane_ctl.feed_zero = (cnt_r >= CNT_W'(ST_W));
        cnt_nxt            = cnt_r + 1'b1;
        if (cnt_r == (avg_mode_r ? LAST_AVG : LAST_WILDER)) begin
          state_nxt = S_POST;
        end
      end
      S_POST: begin
        if (avg_mode_r) begin
          avg_g_nxt = quot_g;
          avg_l_nxt = quot_l;
          state_nxt = S_OUT;
        end else begin
          avg_g_nxt = post_g;
          avg_l_nxt = post_l;
          state_nxt = S_RSTART;
        end
      end
      S_RSTART: begin
        ratio_start = 1'b1;
        state_nxt   = S_RWAIT;
      end
      S_RWAIT: begin
        if (ratio_done) begin
          res_value_nxt = ratio_q;
          res_ok_nxt    = 1'b1;
          state_nxt     = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_value_nxt = res_value_r;
          out_ok_nxt    = res_ok_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      prev_r      <= '0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      prev_r      <= prev_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    price_r     <= price_nxt;
    first_r     <= first_nxt;
    n_r         <= n_nxt;
    gain_r      <= gain_nxt;
    loss_r      <= loss_nxt;
    avg_g_r     <= avg_g_nxt;
    avg_l_r     <= avg_l_nxt;
    ge_g_r      <= ge_g_nxt;
    ge_l_r      <= ge_l_nxt;
    avg_mode_r  <= avg_mode_nxt;
    cnt_r       <= cnt_nxt;
    res_value_r <= res_value_nxt;
    res_ok_r    <= res_ok_nxt;
    out_value_r <= out_value_nxt;
    out_ok_r    <= out_ok_nxt;
  end

  rsiw_div_lane u_lane_gain (
    .clk      (clk),
    .ctl      (lane_ctl),
    .load_val (lane_g_val),
    .divisor  (p_eff),
    .quot     (quot_g),
    .rem_nz   (nz_g)
  );

  rsiw_div_lane u_lane_loss (
    .clk      (clk),
    .ctl      (lane_ctl),
    .load_val (lane_l_val),
    .divisor  (p_eff),
    .quot     (quot_l),
    .rem_nz   (nz_l)
  );

  rsiw_ratio u_ratio (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ratio_start),
    .g_in  (avg_g_r),
    .l_in  (avg_l_r),
    .done  (ratio_done),
    .q     (ratio_q)
  );

  assign in_stall      = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_rsi_value = out_value_r;
  assign out_valid_res = out_ok_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while a word was still in flight");

  a_warmup_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_valid_res) |-> (out_rsi_value == '0))
    else $error("warm-up result carries a nonzero value");

  a_rsi_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_valid_res) |-> (out_rsi_value <= RSI_FULL))
    else $error("RSI above full scale");

  a_ratio_owner: assert property (@(posedge clk) disable iff (!rst_n)
    ratio_done |-> (state_r == S_RWAIT))
    else $error("ratio unit finished with no one waiting");

  a_wilder_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && !avg_mode_r) |-> (cnt_r < CNT_W'(ST_W)))
    else $error("smoothing division ran past the dividend");

endmodule
